>>> sv/flight_supervisor_tick_controller_assert.svh
// Assertion macros for the flight supervisor tick controller.
`ifndef FLIGHT_SUPERVISOR_TICK_CONTROLLER_ASSERT_SVH
`define FLIGHT_SUPERVISOR_TICK_CONTROLLER_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled during reset.
`define FSTC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fstc assertion failed");

// Next-cycle implication, disabled during reset.
`define FSTC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fstc assertion failed");

`else

`define FSTC_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define FSTC_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> sv/fstc_pkg.sv
// Shared types and constants for the flight supervisor tick controller.
package fstc_pkg;

    localparam int CNT_W   = 16;
    localparam int CFG_W   = 16;
    localparam int LEVEL_W = 8;
    localparam int IDX_W   = 3;

    localparam logic [CFG_W-1:0] RST_BATTERY_PERIOD   = CFG_W'(100);
    localparam logic [CFG_W-1:0] RST_BLINK_PERIOD     = CFG_W'(100);
    localparam logic [CFG_W-1:0] RST_SETTLE_BLINKS    = CFG_W'(165);
    localparam logic [CFG_W-1:0] RST_HEARTBEAT_PERIOD = CFG_W'(300);
    localparam logic [CFG_W-1:0] RST_LINK_TIMEOUT     = CFG_W'(500);

    typedef enum logic [IDX_W-1:0] {
        REG_BATTERY_PERIOD   = 3'd0,
        REG_BLINK_PERIOD     = 3'd1,
        REG_SETTLE_BLINKS    = 3'd2,
        REG_HEARTBEAT_PERIOD = 3'd3,
        REG_LINK_TIMEOUT     = 3'd4
    } reg_index_t;

    typedef struct packed {
        logic               armed;
        logic               link_active;
        logic [LEVEL_W-1:0] battery_level;
    } tick_t;

    typedef struct packed {
        logic               led_red;
        logic               led_green;
        logic               led_blue;
        logic               battery_report;
        logic [LEVEL_W-1:0] report_level;
        logic               watchdog_feed;
        logic               yaw_zero_capture;
        logic               link_lost;
    } result_t;

endpackage

>>> sv/flight_supervisor_tick_controller.sv
// Flight supervisor tick controller: LED, watchdog, battery and link supervision per tick.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+---------------------------------
//  tick     | tick_valid / tick_ready    | fstc_pkg::tick_t (armed, link, level)
//  result   | result_valid / result_ready| fstc_pkg::result_t (LEDs, pulses, flag)
//  config   | cfg_write (no handshake)   | cfg_index, cfg_data
//
// One beat per cycle sustained while result_ready holds high. A tick beat lands
// in the input register, and its result is then written into the result register,
// which offers it. All state updates happen in that one pass of counter compares.
// Reset (rst_n low, async) clears the counters and flags, turns the LEDs off and
// loads the register defaults. A stalled result holds the input register; the
// tick side stays open as long as the input register is empty or draining into
// the result register.
`include "flight_supervisor_tick_controller_assert.svh"

module flight_supervisor_tick_controller (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             tick_valid,
    output logic                             tick_ready,
    input  fstc_pkg::tick_t                  tick,
    output logic                             result_valid,
    input  logic                             result_ready,
    output fstc_pkg::result_t                result,
    input  logic                             cfg_write,
    input  logic [fstc_pkg::IDX_W-1:0]       cfg_index,
    input  logic [fstc_pkg::CFG_W-1:0]       cfg_data
);
    import fstc_pkg::*;

    // Configuration registers
    logic [CFG_W-1:0] battery_period_reg;
    logic [CFG_W-1:0] blink_period_reg;
    logic [CFG_W-1:0] settle_blinks_reg;
    logic [CFG_W-1:0] heartbeat_period_reg;
    logic [CFG_W-1:0] link_timeout_reg;

    // Pipeline registers
    tick_t   tick_reg;
    logic    tick_valid_reg;
    logic    tick_valid_next;
    result_t result_reg;
    result_t result_next;
    logic    result_valid_reg;
    logic    result_valid_next;
    logic    advance;

    // Supervisor state
    logic [CNT_W-1:0] heartbeat_count_reg, heartbeat_count_next;
    logic [CNT_W-1:0] battery_count_reg, battery_count_next;
    logic [CNT_W-1:0] blink_count_reg, blink_count_next;
    logic [CNT_W-1:0] blinks_done_reg, blinks_done_next;
    logic [CNT_W-1:0] silence_count_reg, silence_count_next;
    logic             yaw_settled_reg, yaw_settled_next;
    logic             blink_phase_reg, blink_phase_next;
    logic             lost_flag_reg, lost_flag_next;
    logic [2:0]       led_reg, led_next;    // {red, green, blue}, 1 = off

    // Handshake: the input register moves on whenever the result slot is free
    // or being emptied this cycle.
    assign advance           = tick_valid_reg && (!result_valid_reg || result_ready);
    assign tick_ready        = !tick_valid_reg || advance;
    assign tick_valid_next   = (tick_valid && tick_ready) || (tick_valid_reg && !advance);
    assign result_valid_next = advance || (result_valid_reg && !result_ready);
    assign result_valid      = result_valid_reg;
    assign result            = result_reg;

    // Configuration writes; indexes beyond the list are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            battery_period_reg   <= RST_BATTERY_PERIOD;
            blink_period_reg     <= RST_BLINK_PERIOD;
            settle_blinks_reg    <= RST_SETTLE_BLINKS;
            heartbeat_period_reg <= RST_HEARTBEAT_PERIOD;
            link_timeout_reg     <= RST_LINK_TIMEOUT;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_BATTERY_PERIOD:   battery_period_reg   <= cfg_data;
                REG_BLINK_PERIOD:     blink_period_reg     <= cfg_data;
                REG_SETTLE_BLINKS:    settle_blinks_reg    <= cfg_data;
                REG_HEARTBEAT_PERIOD: heartbeat_period_reg <= cfg_data;
                REG_LINK_TIMEOUT:     link_timeout_reg     <= cfg_data;
                default:              ;
            endcase
        end
    end

    // One tick's worth of supervision, in the order: battery, blink, settle,
    // heartbeat, link. The heartbeat sees the lost flag from before this tick.
    always_comb
    begin
        logic r, g, b;
        logic report, feed, capture;

        r = led_reg[2];
        g = led_reg[1];
        b = led_reg[0];
        report  = 1'b0;
        feed    = 1'b0;
        capture = 1'b0;

        heartbeat_count_next = heartbeat_count_reg + CNT_W'(1);
        battery_count_next   = battery_count_reg + CNT_W'(1);
        blink_count_next     = blink_count_reg;
        blinks_done_next     = blinks_done_reg;
        silence_count_next   = silence_count_reg;
        yaw_settled_next     = yaw_settled_reg;
        blink_phase_next     = blink_phase_reg;
        lost_flag_next       = lost_flag_reg;

        // battery report
        if (battery_count_next >= CNT_W'(battery_period_reg))
        begin
            battery_count_next = '0;
            report             = 1'b1;
        end

        // yaw-settling blink and settle check
        if (!yaw_settled_reg)
        begin
            blink_count_next = blink_count_reg + CNT_W'(1);
            if (blink_count_next >= CNT_W'(blink_period_reg))
            begin
                blink_count_next = '0;
                blinks_done_next = blinks_done_reg + CNT_W'(1);
                r                = blink_phase_reg;
                g                = blink_phase_reg;
                blink_phase_next = !blink_phase_reg;
                b                = 1'b1;
            end
            if (blinks_done_next >= CNT_W'(settle_blinks_reg))
            begin
                blinks_done_next = '0;
                capture          = 1'b1;
                yaw_settled_next = 1'b1;
            end
        end

        // heartbeat: watchdog feed and status LED
        if (heartbeat_count_next >= CNT_W'(heartbeat_period_reg))
        begin
            heartbeat_count_next = '0;
            feed                 = 1'b1;
            if (!lost_flag_reg)
            begin
                if (tick_reg.armed)
                begin
                    r = 1'b1;
                    g = 1'b1;
                    b = !b;
                end
                else if (yaw_settled_next)
                begin
                    r = 1'b1;
                    b = 1'b1;
                    g = !g;
                end
            end
            else
            begin
                r = !r;
                g = 1'b1;
                b = 1'b1;
            end
        end

        // link supervision, only while armed
        if (tick_reg.armed)
        begin
            if (!tick_reg.link_active)
            begin
                silence_count_next = silence_count_reg + CNT_W'(1);
            end
            else
            begin
                silence_count_next = '0;
                lost_flag_next     = 1'b0;
            end
            if (silence_count_next >= CNT_W'(link_timeout_reg))
            begin
                silence_count_next = '0;
                lost_flag_next     = 1'b1;
            end
        end

        led_next = {r, g, b};

        result_next.led_red          = r;
        result_next.led_green        = g;
        result_next.led_blue         = b;
        result_next.battery_report   = report;
        result_next.report_level     = report ? tick_reg.battery_level : '0;
        result_next.watchdog_feed    = feed;
        result_next.yaw_zero_capture = capture;
        result_next.link_lost        = lost_flag_next;
    end

    // Control and state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_valid_reg      <= 1'b0;
            result_valid_reg    <= 1'b0;
            heartbeat_count_reg <= '0;
            battery_count_reg   <= '0;
            blink_count_reg     <= '0;
            blinks_done_reg     <= '0;
            silence_count_reg   <= '0;
            yaw_settled_reg     <= 1'b0;
            blink_phase_reg     <= 1'b0;
            lost_flag_reg       <= 1'b0;
            led_reg             <= '1;
        end
        else
        begin
            tick_valid_reg   <= tick_valid_next;
            result_valid_reg <= result_valid_next;
            if (advance)
            begin
                heartbeat_count_reg <= heartbeat_count_next;
                battery_count_reg   <= battery_count_next;
                blink_count_reg     <= blink_count_next;
                blinks_done_reg     <= blinks_done_next;
                silence_count_reg   <= silence_count_next;
                yaw_settled_reg     <= yaw_settled_next;
                blink_phase_reg     <= blink_phase_next;
                lost_flag_reg       <= lost_flag_next;
                led_reg             <= led_next;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (tick_valid && tick_ready)
        begin
            tick_reg <= tick;
        end
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    // Settling is permanent once reached.
    `FSTC_ASSERT_NEXT(a_settled_sticky, clk, rst_n, yaw_settled_reg, yaw_settled_reg)
    // A capture pulse leaves yaw settled.
    `FSTC_ASSERT_NEXT(a_capture_settles, clk, rst_n, advance && result_next.yaw_zero_capture, yaw_settled_reg)
    // A watchdog feed restarts the heartbeat count.
    `FSTC_ASSERT_NEXT(a_feed_restarts, clk, rst_n, advance && result_next.watchdog_feed, heartbeat_count_reg == '0)
    // An empty result slot never blocks the tick side.
    `FSTC_ASSERT_IMPL(a_ready_when_free, clk, rst_n, !result_valid_reg, tick_ready)

endmodule
